// ----- hdl/maximal_rectangle_binary_matrix_defines.svh -----
// ----------------------------------------------------------------------------
// Maximal rectangle block: assertion macros
// Shared concurrent-assertion forms, clocked on the rising edge and held off
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MAXIMAL_RECTANGLE_BINARY_MATRIX_DEFINES_SVH
`define MAXIMAL_RECTANGLE_BINARY_MATRIX_DEFINES_SVH

// Same-cycle implication.
`define MRBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrbm same-cycle check failed");

// Next-cycle implication.
`define MRBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrbm next-cycle check failed");

`endif

// ----- hdl/mrbm_pkg.sv -----
// ----------------------------------------------------------------------------
// mrbm_pkg
// Types and constants shared by the maximal rectangle controller and datapath.
// ----------------------------------------------------------------------------
package mrbm_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 256;

    localparam int COL_W   = $clog2(MAX_COLS);      // column address
    localparam int WIDTH_W = 7;                     // row width register, span
    localparam int HGT_W   = 9;                     // column height, 0..MAX_ROWS
    localparam int AREA_W  = 15;                    // area result
    localparam int PROD_W  = HGT_W + WIDTH_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SRD,
        ST_SCMP,
        ST_POPW,
        ST_DONE
    } state_t;

    // One histogram stack entry: bar height and its column.
    typedef struct packed {
        logic [HGT_W-1:0] hgt;
        logic [COL_W-1:0] idx;
    } stack_ent_t;

    typedef struct packed {
        logic load_cell;   // take the cell word, read its column height
        logic upd;         // write back the new column height
        logic scan_init;   // clear scan index and stack depth
        logic rd_cur;      // read the height at the scan index
        logic pop;         // drop the stack top, read the entry below
        logic pop_fin;     // work out the popped bar area
        logic advance;     // push the current bar, step the scan index
        logic emit;        // load the result register, clear the matrix
    } cmd_t;

    typedef struct packed {
        logic row_done;
        logic last;
        logic scan_end;
        logic pop_ok;
        logic out_busy;
    } sts_t;

endpackage

// ----- hdl/mrbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrbm_ctrl
// Sequencer for the cell update, the row histogram scan and the result hand-off.
// ----------------------------------------------------------------------------
`include "maximal_rectangle_binary_matrix_defines.svh"

module mrbm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mrbm_pkg::sts_t sts,
    output mrbm_pkg::cmd_t cmd
);

    mrbm_pkg::state_t state_reg;
    mrbm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrbm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mrbm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_cell = 1'b1;
                    state_next    = mrbm_pkg::ST_UPD;
                end
            end
            mrbm_pkg::ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (sts.row_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = mrbm_pkg::ST_SRD;
                end
                else if (sts.last)
                begin
                    state_next = mrbm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = mrbm_pkg::ST_IDLE;
                end
            end
            mrbm_pkg::ST_SRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = mrbm_pkg::ST_SCMP;
            end
            mrbm_pkg::ST_SCMP:
            begin
                priority if (sts.pop_ok)
                begin
                    cmd.pop    = 1'b1;
                    state_next = mrbm_pkg::ST_POPW;
                end
                else if (sts.scan_end)
                begin
                    state_next = sts.last ? mrbm_pkg::ST_DONE : mrbm_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = mrbm_pkg::ST_SRD;
                end
            end
            mrbm_pkg::ST_POPW:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = mrbm_pkg::ST_SCMP;
            end
            mrbm_pkg::ST_DONE:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mrbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrbm_pkg::ST_IDLE;
            end
        endcase
    end

    `MRBM_ASSERT_NEXT(a_accept_to_upd, clk, rst_n, in_valid && in_ready, state_reg == mrbm_pkg::ST_UPD)
    `MRBM_ASSERT_NEXT(a_pop_to_popw, clk, rst_n, cmd.pop, state_reg == mrbm_pkg::ST_POPW)
    `MRBM_ASSERT_NEXT(a_popw_to_scmp, clk, rst_n, state_reg == mrbm_pkg::ST_POPW, state_reg == mrbm_pkg::ST_SCMP)

endmodule

// ----- hdl/mrbm_dp.sv -----
// ----------------------------------------------------------------------------
// mrbm_dp
// Column height memory, histogram stack, area multiplier, running maximum and
// result register.
// ----------------------------------------------------------------------------
`include "maximal_rectangle_binary_matrix_defines.svh"

module mrbm_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [mrbm_pkg::WIDTH_W-1:0]     cfg_data,
    input  logic                             in_cell,
    input  logic                             in_last,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [mrbm_pkg::AREA_W-1:0]      out_area,
    output logic                             out_partial,
    input  mrbm_pkg::cmd_t                   cmd,
    output mrbm_pkg::sts_t                   sts
);

    localparam logic [mrbm_pkg::WIDTH_W-1:0] W_MAX   = mrbm_pkg::WIDTH_W'(mrbm_pkg::MAX_COLS);
    localparam logic [mrbm_pkg::WIDTH_W-1:0] W_ONE   = mrbm_pkg::WIDTH_W'(1);
    localparam logic [mrbm_pkg::HGT_W-1:0]   H_MAX   = mrbm_pkg::HGT_W'(mrbm_pkg::MAX_ROWS);

    logic [mrbm_pkg::WIDTH_W-1:0]  row_width_reg;
    logic [mrbm_pkg::COL_W-1:0]    col_reg;
    logic [mrbm_pkg::COL_W-1:0]    col_next;
    logic                          cell_reg;
    logic                          last_reg;
    logic [mrbm_pkg::MAX_COLS-1:0] hvalid_reg;
    logic [mrbm_pkg::HGT_W-1:0]    hmem [mrbm_pkg::MAX_COLS];
    logic [mrbm_pkg::HGT_W-1:0]    hrd_reg;
    logic                          hrd_vld_reg;
    logic [mrbm_pkg::WIDTH_W-1:0]  scan_i_reg;
    logic [mrbm_pkg::WIDTH_W-1:0]  depth_reg;
    mrbm_pkg::stack_ent_t          smem [mrbm_pkg::MAX_COLS];
    mrbm_pkg::stack_ent_t          srd_reg;
    mrbm_pkg::stack_ent_t          top_reg;
    mrbm_pkg::stack_ent_t          push_ent;
    logic [mrbm_pkg::HGT_W-1:0]    pop_h_reg;
    logic [mrbm_pkg::AREA_W-1:0]   area_reg;
    logic                          area_vld_reg;
    logic [mrbm_pkg::AREA_W-1:0]   best_reg;
    logic                          out_valid_reg;
    logic [mrbm_pkg::AREA_W-1:0]   out_area_reg;
    logic                          out_partial_reg;

    logic [mrbm_pkg::WIDTH_W-1:0]  w_eff;
    logic [mrbm_pkg::WIDTH_W-1:0]  col_inc;
    logic [mrbm_pkg::COL_W-1:0]    hrd_addr;
    logic [mrbm_pkg::HGT_W-1:0]    h_old;
    logic [mrbm_pkg::HGT_W-1:0]    h_new;
    logic [mrbm_pkg::HGT_W-1:0]    cur_h;
    logic                          scan_in_row;
    logic [mrbm_pkg::COL_W-1:0]    srd_addr;
    logic [mrbm_pkg::WIDTH_W-1:0]  left;
    logic [mrbm_pkg::WIDTH_W-1:0]  span;
    logic [mrbm_pkg::PROD_W-1:0]   prod;

    // Width 0 acts as 1, anything above the column count as the column count.
    always_comb
    begin
        priority if (row_width_reg == '0)
        begin
            w_eff = W_ONE;
        end
        else if (row_width_reg > W_MAX)
        begin
            w_eff = W_MAX;
        end
        else
        begin
            w_eff = row_width_reg;
        end
    end

    assign col_inc     = {1'b0, col_reg} + W_ONE;
    assign scan_in_row = scan_i_reg < w_eff;
    assign h_old       = hrd_vld_reg ? hrd_reg : '0;
    assign h_new       = !cell_reg ? '0 : ((h_old >= H_MAX) ? H_MAX : h_old + 1'b1);
    assign cur_h       = (scan_in_row && hrd_vld_reg) ? hrd_reg : '0;
    assign hrd_addr    = cmd.load_cell ? col_reg : scan_i_reg[mrbm_pkg::COL_W-1:0];
    assign col_next    = (col_inc >= w_eff) ? '0 : col_inc[mrbm_pkg::COL_W-1:0];
    assign srd_addr    = depth_reg[mrbm_pkg::COL_W-1:0] - mrbm_pkg::COL_W'(2);
    assign push_ent    = '{hgt: cur_h, idx: scan_i_reg[mrbm_pkg::COL_W-1:0]};
    assign left        = (depth_reg != '0) ? ({1'b0, srd_reg.idx} + W_ONE) : '0;
    assign span        = scan_i_reg - left;
    assign prod        = {{mrbm_pkg::WIDTH_W{1'b0}}, pop_h_reg} * {{mrbm_pkg::HGT_W{1'b0}}, span};

    assign sts.row_done = col_inc >= w_eff;
    assign sts.last     = last_reg;
    assign sts.scan_end = !scan_in_row;
    assign sts.pop_ok   = (depth_reg != '0) && (top_reg.hgt >= cur_h);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign out_area    = out_area_reg;
    assign out_partial = out_partial_reg;

    // Column height memory.
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            hmem[col_reg] <= h_new;
        end
        if (cmd.load_cell || cmd.rd_cur)
        begin
            hrd_reg <= hmem[hrd_addr];
        end
    end

    // Histogram stack memory.
    always_ff @(posedge clk)
    begin
        if (cmd.advance && scan_in_row)
        begin
            smem[depth_reg[mrbm_pkg::COL_W-1:0]] <= push_ent;
        end
        if (cmd.pop)
        begin
            srd_reg <= smem[srd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_cell)
        begin
            cell_reg <= in_cell;
            last_reg <= in_last;
        end
        if (cmd.advance && scan_in_row)
        begin
            top_reg <= push_ent;
        end
        else if (cmd.pop_fin && depth_reg != '0)
        begin
            top_reg <= srd_reg;
        end
        if (cmd.pop)
        begin
            pop_h_reg <= top_reg.hgt;
        end
        if (cmd.pop_fin)
        begin
            area_reg <= prod[mrbm_pkg::AREA_W-1:0];
        end
        if (cmd.emit)
        begin
            out_area_reg    <= best_reg;
            out_partial_reg <= col_reg != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= W_MAX;
            col_reg       <= '0;
            hvalid_reg    <= '0;
            hrd_vld_reg   <= 1'b0;
            scan_i_reg    <= '0;
            depth_reg     <= '0;
            area_vld_reg  <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                row_width_reg <= cfg_data;
            end
            if (cmd.load_cell || cmd.rd_cur)
            begin
                hrd_vld_reg <= hvalid_reg[hrd_addr];
            end
            area_vld_reg <= cmd.pop_fin;
            if (cmd.emit)
            begin
                // drop the matrix state for the next run
                col_reg    <= '0;
                hvalid_reg <= '0;
                best_reg   <= '0;
            end
            else
            begin
                if (cmd.upd)
                begin
                    col_reg             <= col_next;
                    hvalid_reg[col_reg] <= 1'b1;
                end
                if (area_vld_reg && area_reg > best_reg)
                begin
                    best_reg <= area_reg;
                end
            end
            if (cmd.scan_init)
            begin
                scan_i_reg <= '0;
                depth_reg  <= '0;
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_reg - W_ONE;
            end
            else if (cmd.advance && scan_in_row)
            begin
                depth_reg  <= depth_reg + W_ONE;
                scan_i_reg <= scan_i_reg + W_ONE;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `MRBM_ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= W_MAX && depth_reg <= scan_i_reg)
    `MRBM_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, cmd.pop, depth_reg != '0 && !cmd.advance)
    `MRBM_ASSERT_NEXT(a_emit_clears, clk, rst_n, cmd.emit, best_reg == '0 && col_reg == '0 && out_valid_reg)

endmodule

// ----- hdl/maximal_rectangle_binary_matrix.sv -----
// ----------------------------------------------------------------------------
// maximal_rectangle_binary_matrix
// Largest all-ones rectangle of a binary matrix streamed one cell per word.
//
//   Channel   Dir  Handshake                 Payload
//   cfg       in   cfg_valid/cfg_ready       cfg_data = row_width
//   s_axis    in   s_axis_tvalid/tready      tdata[0] cell_req, tlast matrix_end
//   m_axis    out  m_axis_tvalid/tready      tdata[14:0] max_area, tuser[0] partial_row
//
// A cell takes a height memory read, then a write-back.
// A row-closing cell adds a read and a compare step for each column and for
// the flush position past the last column, plus a pop and an area step per
// stack pop (every column is popped once), serialized by the single read port
// of the height and stack memories; a matrix_end cell adds a result-register load.
// Reset is asynchronous; column heights are cleared by per-column valid bits,
// so no clearing pass is needed.
// One result is held in the output register; input stalls while a cell or row
// scan runs, and when the next result is ready before the previous one is taken.
// ----------------------------------------------------------------------------
module maximal_rectangle_binary_matrix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,       // row_width
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] cell_req, [7:1] zero
    input  logic        s_axis_tlast,   // matrix_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [14:0] max_area, [15] zero
    output logic [0:0]  m_axis_tuser    // [0] partial_row
);

    mrbm_pkg::cmd_t                 cmd;
    mrbm_pkg::sts_t                 sts;
    logic [mrbm_pkg::AREA_W-1:0]    out_area;
    logic                           out_partial;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {1'b0, out_area};
    assign m_axis_tuser = out_partial;

    mrbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrbm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_cell     (s_axis_tdata[0]),
        .in_last     (s_axis_tlast),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_area    (out_area),
        .out_partial (out_partial),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: maximal rectangle block testbench
// Streams binary matrices cell by cell into the block and predicts the largest
// all-ones rectangle with its own per-column height and histogram stack
// model. Each result word is checked field by field against the queued
// prediction. Covers row widths from 0 to 127, width changes mid-row,
// saturating column runs, partial last rows and several pacing mixes on both
// stream sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned AREA_CAP          = 32767;
    localparam int unsigned DRAIN_CYCLES      = 300;
    localparam int unsigned RESULT_WAIT_LIMIT = 200000;

    typedef enum int unsigned {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [mrbm_pkg::AREA_W-1:0] area;
        logic                        partial;
    } matrix_result_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [mrbm_pkg::WIDTH_W-1:0] cfg_data     = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata  = '0;     // [0] cell_req, [7:1] zero
    logic                        s_axis_tlast  = 1'b0;   // matrix_end
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [15:0]                 m_axis_tdata;           // [14:0] max_area, [15] zero
    logic [0:0]                  m_axis_tuser;           // [0] partial_row

    // Matrix model state
    logic [mrbm_pkg::WIDTH_W-1:0] width_reg = 7'd64;
    int unsigned        col_hgt [mrbm_pkg::MAX_COLS] = '{default: 0};
    int unsigned        col_pos   = 0;
    int unsigned        best_area = 0;

    matrix_result_t     expected_results [$];
    matrix_result_t     oldest;

    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        cells_sent     = 0;
    int unsigned        results_seen   = 0;
    int unsigned        errors         = 0;

    maximal_rectangle_binary_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word: max_area %0d partial_row %0d",
                         $time, m_axis_tdata[14:0], m_axis_tuser[0]);
                errors++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (m_axis_tdata[14:0] !== oldest.area)
                begin
                    $display("%0t: max_area mismatch: expected %0d actual %0d",
                             $time, oldest.area, m_axis_tdata[14:0]);
                    errors++;
                end
                if (m_axis_tuser[0] !== oldest.partial)
                begin
                    $display("%0t: partial_row mismatch: expected %0d actual %0d",
                             $time, oldest.partial, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > mrbm_pkg::MAX_COLS)
            return mrbm_pkg::MAX_COLS;
        return 32'(width_reg);
    endfunction

    // Largest rectangle under the first w bars; position w flushes the stack.
    function automatic int unsigned largest_bar_area(int unsigned w);
        int unsigned stk [mrbm_pkg::MAX_COLS + 1];
        int unsigned depth, top, left, cur, area, best, i;
        best  = 0;
        depth = 0;
        for (i = 0; i <= w; i++)
        begin
            cur = (i < w) ? col_hgt[i] : 0;
            while (depth > 0 && col_hgt[stk[depth - 1]] >= cur)
            begin
                top = stk[depth - 1];
                depth--;
                left = (depth > 0) ? stk[depth - 1] + 1 : 0;
                area = col_hgt[top] * (i - left);
                if (area > AREA_CAP)
                    area = AREA_CAP;
                if (area > best)
                    best = area;
            end
            if (i < w)
            begin
                stk[depth] = i;
                depth++;
            end
        end
        return best;
    endfunction

    function automatic void apply_cell(bit cell_val, bit last);
        int unsigned w, col, row_best;
        matrix_result_t res;
        w   = eff_width();
        col = col_pos % mrbm_pkg::MAX_COLS;
        if (!cell_val)
            col_hgt[col] = 0;
        else if (col_hgt[col] < mrbm_pkg::MAX_ROWS)
            col_hgt[col]++;
        if (col + 1 >= w)
        begin
            row_best = largest_bar_area(w);
            if (row_best > best_area)
                best_area = row_best;
            col_pos = 0;
        end
        else
            col_pos = col + 1;
        if (last)
        begin
            res.area    = best_area[mrbm_pkg::AREA_W-1:0];
            res.partial = (col_pos != 0);
            expected_results.push_back(res);
            col_hgt   = '{default: 0};
            col_pos   = 0;
            best_area = 0;
        end
    endfunction

    task automatic set_pace(pace_t pace);
        case (pace)
            PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 72; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default:         begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    task automatic send_cell(bit cell_val, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, cell_val};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_cell(cell_val, last);
        cells_sent++;
    endtask

    // Hold input until every queued result is out, then let the block settle.
    task automatic wait_results_done();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0 && waited < RESULT_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            errors++;
            expected_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_width(logic [mrbm_pkg::WIDTH_W-1:0] value);
        wait_results_done();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = value;
    endtask

    task automatic send_cells(logic [31:0] bits, int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            send_cell(bits[k], k == count - 1);
    endtask

    task automatic test_basic_matrices();
        set_pace(PACE_FULL);
        send_cell(1'b1, 1'b1);                  // default width: row never closes
        write_row_width(7'd3);
        send_cells(32'b110_111_011, 9);         // rows 011 / 111 / 110, low bit first
        send_cells(32'b000, 3);
    endtask

    task automatic test_width_extremes();
        write_row_width(7'd0);                  // acts as width 1
        send_cells(32'b1011, 4);
        write_row_width(7'd127);                // acts as full width
        send_cells(32'b101, 3);
        write_row_width(7'd1);
        send_cells(32'b1, 1);
    endtask

    task automatic test_width_change_mid_row();
        write_row_width(7'd4);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        write_row_width(7'd2);                  // column 2 now closes the row
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b1);
    endtask

    task automatic test_tall_runs();
        int unsigned k;
        set_pace(PACE_BOTH);
        write_row_width(7'd1);
        for (k = 0; k < 270; k++)
            send_cell(1'b1, k == 269);
    endtask

    function automatic logic [mrbm_pkg::WIDTH_W-1:0] pick_width();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 7'($urandom_range(1, 8));
        if (r < 80)
            return 7'($urandom_range(9, 20));
        if (r < 88)
            return ($urandom_range(1)) ? 7'd64 : 7'($urandom_range(21, 63));
        if (r < 94)
            return 7'd0;
        return 7'($urandom_range(65, 127));
    endfunction

    task automatic send_random_matrix();
        int unsigned w, rows, count, density, k;
        w       = eff_width();
        rows    = (w > 16) ? $urandom_range(1, 3) : $urandom_range(1, 12);
        count   = rows * w;
        density = ($urandom_range(1)) ? $urandom_range(80, 99) : $urandom_range(20, 79);
        // Cut some matrices short inside the last row.
        if (w > 1 && $urandom_range(99) < 15)
            count = (rows - 1) * w + $urandom_range(1, w - 1);
        for (k = 0; k < count; k++)
        begin
            if (k + 1 < count && $urandom_range(999) < 4)
                write_row_width(pick_width());
            send_cell($urandom_range(99) < density, k == count - 1);
        end
    endtask

    task automatic test_random_matrices(pace_t pace, int unsigned cell_budget);
        int unsigned start;
        set_pace(pace);
        start = cells_sent;
        while (cells_sent - start < cell_budget)
        begin
            if ($urandom_range(99) < 35)
                write_row_width(pick_width());
            else if ($urandom_range(99) < 5)
                wait_results_done();
            send_random_matrix();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_matrices();
        test_width_extremes();
        test_width_change_mid_row();
        test_tall_runs();
        test_random_matrices(PACE_FULL, 240);
        test_random_matrices(PACE_SEND_IDLE, 240);
        test_random_matrices(PACE_RECV_STALL, 240);
        test_random_matrices(PACE_BOTH, 240);
        wait_results_done();
        $display("Checked %0d matrix results from %0d cells, widths 0 to 127,",
                 results_seen, cells_sent);
        $display("mid-row width changes, saturating runs and four pacing mixes.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
